// ===== sv/cbti_pkg.sv =====
package cbti_pkg;

  localparam int CNT_W      = 7;
  localparam int IDX_W      = 6;
  localparam int VAL_W      = 32;
  localparam int POS_W      = 24;
  localparam int IN_DATA_W  = 96;
  localparam int OUT_DATA_W = 48;
  localparam int CFG_IDX_W  = 1;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [CNT_W-1:0] CNT_RESET = 7'd64;
  localparam logic [CNT_W-1:0] CNT_MIN   = 7'd2;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_ROWS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS = 1'b1;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_QUERY = 2'd1,
    CMD_SKIP  = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    logic [3:0]              pad;
    logic signed [POS_W-1:0] pos_col;
    logic signed [POS_W-1:0] pos_row;
    logic [VAL_W-1:0]        entry_value;
    logic [IDX_W-1:0]        load_col;
    logic [IDX_W-1:0]        load_row;
  } in_payload_t;

  typedef struct packed {
    logic [3:0]       pad;
    logic [IDX_W-1:0] base_col;
    logic [IDX_W-1:0] base_row;
    logic [VAL_W-1:0] interp_value;
  } out_payload_t;

  typedef struct packed {
    cmd_kind_t               kind;
    logic [IDX_W-1:0]        load_row;
    logic [IDX_W-1:0]        load_col;
    logic [VAL_W-1:0]        entry_value;
    logic signed [POS_W-1:0] pos_row;
    logic signed [POS_W-1:0] pos_col;
  } cmd_t;

  function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] reg_val,
                                                 input int max_val);
    logic [CNT_W-1:0] res;
    if (reg_val < CNT_MIN) begin
      res = CNT_MIN;
    end else if (int'(reg_val) > max_val) begin
      res = CNT_W'(max_val);
    end else begin
      res = reg_val;
    end
    return res;
  endfunction

endpackage

// ===== sv/cbti_ram.sv =====
module cbti_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== sv/cbti_front.sv =====
module cbti_front #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [cbti_pkg::IN_DATA_W-1:0] s_tdata,
  input  logic                           s_tuser,
  output logic                           push_valid,
  input  logic                           push_ready,
  output cbti_pkg::cmd_t                 push_cmd
);

  import cbti_pkg::*;

  in_payload_t pl;
  logic        in_range;

  assign pl       = in_payload_t'(s_tdata);
  assign in_range = (int'(pl.load_row) < MAX_ROWS) && (int'(pl.load_col) < MAX_COLS);

  always_comb begin
    push_cmd.load_row    = pl.load_row;
    push_cmd.load_col    = pl.load_col;
    push_cmd.entry_value = pl.entry_value;
    push_cmd.pos_row     = pl.pos_row;
    push_cmd.pos_col     = pl.pos_col;
    if (s_tuser == OP_QUERY) begin
      push_cmd.kind = CMD_QUERY;
    end else if (in_range) begin
      push_cmd.kind = CMD_LOAD;
    end else begin
      push_cmd.kind = CMD_SKIP;
    end
  end

  assign push_valid = s_tvalid;
  assign s_tready   = push_ready;

endmodule

// ===== sv/cbti_queue.sv =====
module cbti_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  cbti_pkg::cmd_t push_cmd,
  output logic           pop_valid,
  input  logic           pop_ready,
  output cbti_pkg::cmd_t pop_cmd,
  output logic [1:0]     level
);

  import cbti_pkg::*;

  cmd_t entries [QUEUE_DEPTH];
  logic wr_ptr;
  logic rd_ptr;
  logic push_fire;
  logic pop_fire;

  assign push_ready = (level != 2'(QUEUE_DEPTH));
  assign pop_valid  = (level != 2'd0);
  assign pop_cmd    = entries[rd_ptr];
  assign push_fire  = push_valid && push_ready;
  assign pop_fire   = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      level  <= 2'd0;
    end else begin
      if (push_fire) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop_fire) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push_fire && !pop_fire) begin
        level <= level + 2'd1;
      end else if (pop_fire && !push_fire) begin
        level <= level - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_fire) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

// ===== sv/cbti_back.sv =====
module cbti_back #(
  parameter int MAX_ROWS  = 64,
  parameter int MAX_COLS  = 64,
  parameter int FRAC_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  pop_valid,
  output logic                                  pop_ready,
  input  cbti_pkg::cmd_t                        pop_cmd,
  input  logic [cbti_pkg::CNT_W-1:0]            rows_eff,
  input  logic [cbti_pkg::CNT_W-1:0]            cols_eff,
  output logic                                  ram_we,
  output logic [$clog2(MAX_ROWS*MAX_COLS)-1:0]  ram_addr,
  output logic [cbti_pkg::VAL_W-1:0]            ram_wdata,
  input  logic [cbti_pkg::VAL_W-1:0]            ram_rdata,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  output logic [cbti_pkg::OUT_DATA_W-1:0]       m_tdata
);

  import cbti_pkg::*;

  localparam int AW = $clog2(MAX_ROWS * MAX_COLS);
  localparam int WW = FRAC_BITS + 1;
  localparam int PW = VAL_W + WW;
  localparam logic [WW-1:0] ONE_W  = WW'(1) << FRAC_BITS;
  localparam logic [PW-1:0] HALF_W = PW'(1) << (FRAC_BITS - 1);
  localparam logic [AW-1:0] ROW_STEP = AW'(MAX_COLS);

  typedef enum logic {ST_IDLE, ST_MAC} state_t;

  state_t           state;
  logic [2:0]       step;
  logic [CNT_W-1:0] base_row;
  logic [CNT_W-1:0] base_col;
  logic [WW-1:0]    wr;
  logic [WW-1:0]    wc;
  logic [AW-1:0]    a00;
  logic [PW-1:0]    prod;
  logic [PW-1:0]    acc;
  logic [VAL_W-1:0] t0;

  logic [POS_W-1:0] fl_row;
  logic [POS_W-1:0] fl_col;
  logic [CNT_W-1:0] nb_row;
  logic [CNT_W-1:0] nb_col;
  logic [WW-1:0]    nw_row;
  logic [WW-1:0]    nw_col;
  logic [AW-1:0]    head_addr;
  logic [AW-1:0]    load_addr;
  logic [VAL_W-1:0] mul_a;
  logic [WW-1:0]    mul_w;
  logic [VAL_W-1:0] acc_val;
  logic             out_free;
  out_payload_t     out_pl;

  assign fl_row = pop_cmd.pos_row >>> FRAC_BITS;
  assign fl_col = pop_cmd.pos_col >>> FRAC_BITS;

  always_comb begin
    if (pop_cmd.pos_row[POS_W-1]) begin
      nb_row = '0;
      nw_row = ONE_W;
    end else if (fl_row >= POS_W'(rows_eff) - POS_W'(1)) begin
      nb_row = rows_eff - CNT_MIN;
      nw_row = '0;
    end else begin
      nb_row = fl_row[CNT_W-1:0];
      nw_row = ONE_W - WW'(pop_cmd.pos_row[FRAC_BITS-1:0]);
    end
    if (pop_cmd.pos_col[POS_W-1]) begin
      nb_col = '0;
      nw_col = ONE_W;
    end else if (fl_col >= POS_W'(cols_eff) - POS_W'(1)) begin
      nb_col = cols_eff - CNT_MIN;
      nw_col = '0;
    end else begin
      nb_col = fl_col[CNT_W-1:0];
      nw_col = ONE_W - WW'(pop_cmd.pos_col[FRAC_BITS-1:0]);
    end
  end

  assign head_addr = AW'(int'(nb_row) * MAX_COLS + int'(nb_col));
  assign load_addr = AW'(int'(pop_cmd.load_row) * MAX_COLS + int'(pop_cmd.load_col));
  assign pop_ready = (state == ST_IDLE);
  assign acc_val   = acc[FRAC_BITS +: VAL_W];
  assign out_free  = !m_tvalid || m_tready;
  assign ram_wdata = pop_cmd.entry_value;

  always_comb begin
    ram_we   = 1'b0;
    ram_addr = a00;
    if (state == ST_IDLE) begin
      if (pop_valid && pop_cmd.kind == CMD_LOAD) begin
        ram_we   = 1'b1;
        ram_addr = load_addr;
      end else begin
        ram_addr = head_addr;
      end
    end else begin
      priority case (step)
        3'd0:    ram_addr = a00 + AW'(1);
        3'd1:    ram_addr = a00 + ROW_STEP;
        3'd2:    ram_addr = a00 + ROW_STEP + AW'(1);
        default: ram_addr = a00;
      endcase
    end
  end

  // Even steps take the base weight, odd steps its complement.
  always_comb begin
    mul_a = ram_rdata;
    if (step >= 3'd4) begin
      mul_a = (step == 3'd4) ? t0 : acc_val;
    end
    if (step >= 3'd4) begin
      mul_w = step[0] ? ONE_W - wr : wr;
    end else begin
      mul_w = step[0] ? ONE_W - wc : wc;
    end
  end

  always_comb begin
    out_pl              = '0;
    out_pl.interp_value = acc_val;
    out_pl.base_row     = base_row[IDX_W-1:0];
    out_pl.base_col     = base_col[IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      step     <= 3'd0;
      m_tvalid <= 1'b0;
    end else begin
      if (state == ST_MAC && step == 3'd7 && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          step <= 3'd0;
          if (pop_valid && pop_cmd.kind == CMD_QUERY) begin
            base_row <= nb_row;
            base_col <= nb_col;
            wr       <= nw_row;
            wc       <= nw_col;
            a00      <= head_addr;
            state    <= ST_MAC;
          end
        end
        ST_MAC: begin
          if (step != 3'd7) begin
            prod <= mul_a * mul_w;
            step <= step + 3'd1;
          end
          priority case (step)
            3'd1, 3'd3, 3'd5: acc <= prod + HALF_W;
            3'd2, 3'd4, 3'd6: acc <= acc + prod;
            default: ;
          endcase
          if (step == 3'd3) begin
            t0 <= acc_val;
          end
          if (step == 3'd7 && out_free) begin
            m_tdata  <= out_pl;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== sv/clamped_bilinear_table_interpolator.sv =====
// Bilinear interpolator over a coefficient table of up to MAX_ROWS by MAX_COLS 32-bit
// entries. Items with tuser low load one entry (a load outside the table is dropped and
// gives no result); items with tuser high query the table at a signed row and column
// position with FRAC_BITS fraction bits and return one blended value with the clamped
// base indices. Positions below zero clamp to the first entry and positions at or past
// the last index in use clamp to the last entry. A load is written as it is popped; a
// query occupies the back end to issue the first read and for eight steps of the
// single shared multiply-accumulate unit, during which the four neighbours are read
// one per cycle from the single-port table memory. A two-entry queue lets new items
// be taken while the back end is busy or a result is waiting. The table is not
// cleared by reset: a query that touches an entry never loaded returns an undefined
// value. The row and column counts may only be changed while the block is idle.
module clamped_bilinear_table_interpolator #(
  parameter int MAX_ROWS  = 64,
  parameter int MAX_COLS  = 64,
  parameter int FRAC_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // load_row, load_col, entry_value, pos_row, pos_col, zero padding
  input  logic [cbti_pkg::IN_DATA_W-1:0]     s_tdata,
  // opcode
  input  logic                               s_tuser,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // interp_value, base_row, base_col, zero padding
  output logic [cbti_pkg::OUT_DATA_W-1:0]    m_tdata,
  input  logic                               cfg_we,
  input  logic [cbti_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [cbti_pkg::CNT_W-1:0]         cfg_wdata
);

  import cbti_pkg::*;

  localparam int AW    = $clog2(MAX_ROWS * MAX_COLS);
  localparam int DEPTH = MAX_ROWS * MAX_COLS;

  logic [CNT_W-1:0] rows_in_use;
  logic [CNT_W-1:0] cols_in_use;
  logic [CNT_W-1:0] rows_eff;
  logic [CNT_W-1:0] cols_eff;

  logic             push_valid;
  logic             push_ready;
  cmd_t             push_cmd;
  logic             pop_valid;
  logic             pop_ready;
  cmd_t             pop_cmd;
  logic [1:0]       q_level;

  logic             ram_we;
  logic [AW-1:0]    ram_addr;
  logic [VAL_W-1:0] ram_wdata;
  logic [VAL_W-1:0] ram_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use <= CNT_RESET;
      cols_in_use <= CNT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_ROWS: rows_in_use <= cfg_wdata;
        REG_COLS: cols_in_use <= cfg_wdata;
      endcase
    end
  end

  assign rows_eff = eff_count(rows_in_use, MAX_ROWS);
  assign cols_eff = eff_count(cols_in_use, MAX_COLS);

  cbti_front #(
    .MAX_ROWS(MAX_ROWS),
    .MAX_COLS(MAX_COLS)
  ) u_front (
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_cmd  (push_cmd)
  );

  cbti_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_cmd  (push_cmd),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_cmd   (pop_cmd),
    .level     (q_level)
  );

  cbti_back #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS),
    .FRAC_BITS(FRAC_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .pop_valid(pop_valid),
    .pop_ready(pop_ready),
    .pop_cmd  (pop_cmd),
    .rows_eff (rows_eff),
    .cols_eff (cols_eff),
    .ram_we   (ram_we),
    .ram_addr (ram_addr),
    .ram_wdata(ram_wdata),
    .ram_rdata(ram_rdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  cbti_ram #(
    .WIDTH(VAL_W),
    .DEPTH(DEPTH)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  a_out_cleared_by_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("Result valid straight after reset.");

  a_queue_fills: assert property (@(posedge clk) disable iff (rst)
    (push_valid && push_ready && !(pop_valid && pop_ready)) |=>
      (q_level == $past(q_level) + 2'd1))
    else $error("Queue level did not follow an input transfer.");

  a_queue_drains: assert property (@(posedge clk) disable iff (rst)
    (pop_valid && pop_ready && !(push_valid && push_ready)) |=>
      (q_level == $past(q_level) - 2'd1))
    else $error("Queue level did not follow a pop by the back end.");

endmodule

// ===== bench/tb_clamped_bilinear_table_interpolator.sv =====
module tb_clamped_bilinear_table_interpolator;
  timeunit 1ns;
  timeprecision 1ps;

  import cbti_pkg::*;

  localparam int TAB_ROWS = 64;
  localparam int TAB_COLS = 64;
  localparam int FRAC = 16;
  localparam longint unsigned ONE_W = 64'd1 << FRAC;
  localparam longint unsigned HALF_W = ONE_W >> 1;
  localparam int LIMIT = 200000;
  localparam int DRAIN_CYCLES = 40;
  localparam int HOLD_CYCLES = 300;
  localparam int NUM_PROBES = 23;
  localparam int NUM_PHASES = 8;
  localparam int FIRST_TARGET = 160;
  localparam int PHASE_ITEMS = 135;

  typedef struct packed {
    logic             op;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic [VAL_W-1:0] value;
    logic [POS_W-1:0] pos_r;
    logic [POS_W-1:0] pos_c;
    logic             typed;
    logic [VAL_W-1:0] exp_value;
    logic [IDX_W-1:0] exp_row;
    logic [IDX_W-1:0] exp_col;
  } probe_t;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic                  s_tuser;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CNT_W-1:0]      cfg_wdata;

  logic [VAL_W-1:0] coeff_shadow [0:TAB_ROWS*TAB_COLS-1];
  bit               entry_loaded [0:TAB_ROWS*TAB_COLS-1];
  logic [CNT_W-1:0] rows_cfg = CNT_RESET;
  logic [CNT_W-1:0] cols_cfg = CNT_RESET;
  out_payload_t     pending_blends [$];

  int items_sent = 0;
  int mismatches = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int rx_stall_pct = 0;
  bit hold_off_req = 1'b0;

  probe_t probes [0:NUM_PROBES-1] = '{
    '{OP_LOAD, 6'd0, 6'd0, 32'hFFFF_FFFF, 24'h0, 24'h0, 1'b0, 32'h0, 6'd0, 6'd0},
    '{OP_LOAD, 6'd0, 6'd1, 32'h0, 24'h0, 24'h0, 1'b0, 32'h0, 6'd0, 6'd0},
    '{OP_LOAD, 6'd1, 6'd0, 32'h0, 24'h0, 24'h0, 1'b0, 32'h0, 6'd0, 6'd0},
    '{OP_LOAD, 6'd1, 6'd1, 32'h0, 24'h0, 24'h0, 1'b0, 32'h0, 6'd0, 6'd0},
    '{OP_LOAD, 6'd62, 6'd62, 32'h0, 24'h0, 24'h0, 1'b0, 32'h0, 6'd0, 6'd0},
    '{OP_LOAD, 6'd62, 6'd63, 32'h0, 24'h0, 24'h0, 1'b0, 32'h0, 6'd0, 6'd0},
    '{OP_LOAD, 6'd63, 6'd62, 32'h0, 24'h0, 24'h0, 1'b0, 32'h0, 6'd0, 6'd0},
    '{OP_LOAD, 6'd63, 6'd63, 32'hFFFF_FFFF, 24'h0, 24'h0, 1'b0, 32'h0, 6'd0, 6'd0},
    '{OP_LOAD, 6'd62, 6'd0, 32'hFFFF_FFFF, 24'h0, 24'h0, 1'b0, 32'h0, 6'd0, 6'd0},
    '{OP_LOAD, 6'd62, 6'd1, 32'h1234_5678, 24'h0, 24'h0, 1'b0, 32'h0, 6'd0, 6'd0},
    '{OP_LOAD, 6'd63, 6'd0, 32'h0, 24'h0, 24'h0, 1'b0, 32'h0, 6'd0, 6'd0},
    '{OP_LOAD, 6'd63, 6'd1, 32'h8000_0000, 24'h0, 24'h0, 1'b0, 32'h0, 6'd0, 6'd0},
    '{OP_QUERY, 6'd0, 6'd0, 32'h0, 24'h800000, 24'h800000, 1'b1, 32'hFFFF_FFFF, 6'd0, 6'd0},
    '{OP_QUERY, 6'd0, 6'd0, 32'h0, 24'h7FFFFF, 24'h7FFFFF, 1'b1, 32'hFFFF_FFFF, 6'd62, 6'd62},
    '{OP_QUERY, 6'd0, 6'd0, 32'h0, 24'h000000, 24'h000000, 1'b1, 32'hFFFF_FFFF, 6'd0, 6'd0},
    '{OP_QUERY, 6'd0, 6'd0, 32'h0, 24'h008000, 24'h000000, 1'b0, 32'h0, 6'd0, 6'd0},
    '{OP_QUERY, 6'd0, 6'd0, 32'h0, 24'h00C000, 24'h004000, 1'b0, 32'h0, 6'd0, 6'd0},
    '{OP_QUERY, 6'd0, 6'd0, 32'h0, 24'h00FFFF, 24'hFF0000, 1'b0, 32'h0, 6'd0, 6'd0},
    '{OP_QUERY, 6'd0, 6'd0, 32'h0, 24'h3EFFFF, 24'h3F0000, 1'b0, 32'h0, 6'd0, 6'd0},
    '{OP_QUERY, 6'd0, 6'd0, 32'h0, 24'h3F0000, 24'hFFFFFF, 1'b0, 32'h0, 6'd0, 6'd0},
    '{OP_LOAD, 6'd63, 6'd63, 32'h0, 24'h0, 24'h0, 1'b0, 32'h0, 6'd0, 6'd0},
    '{OP_QUERY, 6'd0, 6'd0, 32'h0, 24'h7FFFFF, 24'h7FFFFF, 1'b1, 32'h0, 6'd62, 6'd62},
    '{OP_QUERY, 6'd0, 6'd0, 32'h0, 24'h7FFFFF, 24'h800000, 1'b1, 32'h0, 6'd62, 6'd0}
  };

  clamped_bilinear_table_interpolator u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int clamp_count(input logic [CNT_W-1:0] v, input int maxv);
    if (v < 2) begin
      return 2;
    end
    if (int'(v) > maxv) begin
      return maxv;
    end
    return int'(v);
  endfunction

  // Floors the position and pins it to the valid span; the weight belongs to the base.
  function automatic void locate(input logic signed [POS_W-1:0] pos, input int count,
                                 output int base, output longint unsigned weight);
    longint p;
    longint fl;
    p = pos;
    fl = p >>> FRAC;
    if (fl < 0) begin
      base = 0;
      weight = ONE_W;
    end else if (fl >= count - 1) begin
      base = count - 2;
      weight = 0;
    end else begin
      base = int'(fl);
      weight = ONE_W - longint'(pos[FRAC-1:0]);
    end
  endfunction

  function automatic longint unsigned mix(input longint unsigned a, input longint unsigned b,
                                          input longint unsigned w);
    return (a * w + b * (ONE_W - w) + HALF_W) >> FRAC;
  endfunction

  function automatic out_payload_t predict_blend(input logic signed [POS_W-1:0] pr,
                                                 input logic signed [POS_W-1:0] pc);
    int br;
    int bc;
    longint unsigned wr;
    longint unsigned wc;
    longint unsigned t0;
    longint unsigned t1;
    longint unsigned v;
    out_payload_t res;
    locate(pr, clamp_count(rows_cfg, TAB_ROWS), br, wr);
    locate(pc, clamp_count(cols_cfg, TAB_COLS), bc, wc);
    t0 = mix(coeff_shadow[br * TAB_COLS + bc], coeff_shadow[br * TAB_COLS + bc + 1], wc);
    t1 = mix(coeff_shadow[(br + 1) * TAB_COLS + bc],
             coeff_shadow[(br + 1) * TAB_COLS + bc + 1], wc);
    v = mix(t0, t1, wr);
    res = '0;
    res.interp_value = v[VAL_W-1:0];
    res.base_row = IDX_W'(br);
    res.base_col = IDX_W'(bc);
    return res;
  endfunction

  function automatic logic [POS_W-1:0] random_pos(input int count);
    int fl;
    int fr;
    fr = $urandom_range(int'(ONE_W) - 1);
    case ($urandom_range(9))
      0: return POS_W'($urandom);
      1: fl = -int'($urandom_range(3, 1));
      2: fl = count - 1 + int'($urandom_range(3));
      3: begin
        fl = $urandom_range(count - 1);
        fr = 0;
      end
      default: fl = $urandom_range(count - 2);
    endcase
    return POS_W'(fl * int'(ONE_W) + fr);
  endfunction

  task automatic push_item(input logic op, input in_payload_t pl, input bit typed,
                           input out_payload_t typed_exp);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= pl;
    do @(posedge clk); while (!s_tready);
    if (op == OP_QUERY) begin
      pending_blends.push_back(typed ? typed_exp : predict_blend(pl.pos_row, pl.pos_col));
    end else begin
      coeff_shadow[{pl.load_row, pl.load_col}] = pl.entry_value;
      entry_loaded[{pl.load_row, pl.load_col}] = 1'b1;
    end
    items_sent++;
    @(negedge clk);
  endtask

  // A query may only touch entries already loaded, so missing neighbours are loaded first.
  task automatic query_with_loads(input in_payload_t pl);
    int br;
    int bc;
    longint unsigned w;
    in_payload_t ld;
    locate(pl.pos_row, clamp_count(rows_cfg, TAB_ROWS), br, w);
    locate(pl.pos_col, clamp_count(cols_cfg, TAB_COLS), bc, w);
    for (int r = br; r <= br + 1; r++) begin
      for (int c = bc; c <= bc + 1; c++) begin
        if (!entry_loaded[r * TAB_COLS + c]) begin
          ld = pl;
          ld.load_row = IDX_W'(r);
          ld.load_col = IDX_W'(c);
          ld.entry_value = $urandom;
          push_item(OP_LOAD, ld, 1'b0, '0);
        end
      end
    end
    push_item(OP_QUERY, pl, 1'b0, '0);
  endtask

  task automatic random_item();
    in_payload_t pl;
    int nr;
    int nc;
    nr = clamp_count(rows_cfg, TAB_ROWS);
    nc = clamp_count(cols_cfg, TAB_COLS);
    pl = '0;
    pl.load_row = IDX_W'($urandom);
    pl.load_col = IDX_W'($urandom);
    pl.entry_value = $urandom;
    pl.pos_row = POS_W'($urandom);
    pl.pos_col = POS_W'($urandom);
    if ($urandom_range(99) < 35) begin
      if ($urandom_range(3) != 0) begin
        pl.load_row = IDX_W'($urandom_range(nr - 1));
        pl.load_col = IDX_W'($urandom_range(nc - 1));
      end
      case ($urandom_range(7))
        0: pl.entry_value = '0;
        1: pl.entry_value = '1;
        default: ;
      endcase
      push_item(OP_LOAD, pl, 1'b0, '0);
    end else begin
      pl.pos_row = random_pos(nr);
      pl.pos_col = random_pos(nc);
      query_with_loads(pl);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CNT_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    if (idx == REG_ROWS) begin
      rows_cfg = val;
    end else begin
      cols_cfg = val;
    end
    @(negedge clk);
  endtask

  task automatic settle();
    while (pending_blends.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_idling(input int mode);
    case (mode)
      1: begin
        send_idle_pct = 45;
        rx_stall_pct = 0;
      end
      2: begin
        send_idle_pct = 0;
        rx_stall_pct = 45;
      end
      3: begin
        send_idle_pct = 30;
        rx_stall_pct = 30;
      end
      default: begin
        send_idle_pct = 0;
        rx_stall_pct = 0;
      end
    endcase
  endtask

  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_off_req = 1'b0;
      end
      m_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  always @(posedge clk) begin : check_results
    out_payload_t got;
    out_payload_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata;
      if (pending_blends.size() == 0) begin
        if (mismatches < 10) begin
          $display("Unexpected transfer: value %h base (%0d,%0d)",
                   got.interp_value, got.base_row, got.base_col);
        end
        mismatches++;
      end else begin
        want = pending_blends.pop_front();
        if (got.interp_value !== want.interp_value || got.base_row !== want.base_row ||
            got.base_col !== want.base_col) begin
          if (mismatches < 10) begin
            $display("Mismatch: expected %h (%0d,%0d), got %h (%0d,%0d)",
                     want.interp_value, want.base_row, want.base_col,
                     got.interp_value, got.base_row, got.base_col);
          end
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT) begin
      $display("tb_clamped_bilinear_table_interpolator NOT OK");
      $finish;
    end
  end

  initial begin
    in_payload_t pl;
    out_payload_t ex;
    logic [CNT_W-1:0] phase_rows [1:NUM_PHASES-1];
    logic [CNT_W-1:0] phase_cols [1:NUM_PHASES-1];
    phase_rows = '{7'd2, 7'd0, 7'd127, 7'd64, 7'd5, 7'd3, 7'd0};
    phase_cols = '{7'd2, 7'd1, 7'd65, 7'd2, 7'd37, 7'd64, 7'd0};
    phase_rows[NUM_PHASES-1] = CNT_W'($urandom_range(127));
    phase_cols[NUM_PHASES-1] = CNT_W'($urandom_range(127));
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tuser = OP_LOAD;
    s_tdata = '0;
    cfg_we = 1'b0;
    cfg_idx = REG_ROWS;
    cfg_wdata = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int i = 0; i < NUM_PROBES; i++) begin
      pl = '0;
      pl.load_row = probes[i].row;
      pl.load_col = probes[i].col;
      pl.entry_value = probes[i].value;
      pl.pos_row = probes[i].pos_r;
      pl.pos_col = probes[i].pos_c;
      ex = '0;
      ex.interp_value = probes[i].exp_value;
      ex.base_row = probes[i].exp_row;
      ex.base_col = probes[i].exp_col;
      if (probes[i].op == OP_LOAD) begin
        push_item(OP_LOAD, pl, 1'b0, '0);
      end else if (probes[i].typed) begin
        push_item(OP_QUERY, pl, 1'b1, ex);
      end else begin
        query_with_loads(pl);
      end
    end
    while (items_sent < FIRST_TARGET) random_item();

    for (int ph = 1; ph < NUM_PHASES; ph++) begin
      s_tvalid <= 1'b0;
      settle();
      write_reg(REG_ROWS, phase_rows[ph]);
      write_reg(REG_COLS, phase_cols[ph]);
      cfg_we <= 1'b0;
      set_idling((ph == 4) ? 0 : 1 + (ph - 1) % 3);
      hold_off_req = (ph == 4);
      while (items_sent < FIRST_TARGET + ph * PHASE_ITEMS) random_item();
    end

    s_tvalid <= 1'b0;
    settle();
    if (mismatches == 0 && pending_blends.size() == 0) begin
      $display("tb_clamped_bilinear_table_interpolator OK");
    end else begin
      $display("tb_clamped_bilinear_table_interpolator NOT OK");
    end
    $finish;
  end

endmodule
